// ===== design/urjt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urjt_pkg
// Shared constants and controller/datapath interface types for the unlock
// relay jitter timer.
// ----------------------------------------------------------------------------
package urjt_pkg;

    localparam int PERIOD_W  = 19;
    localparam int HALF_W    = 16;
    localparam int RANGE_W   = HALF_W + 1;
    localparam int COUNT_W   = 20;
    localparam int QUIET_W   = 17;
    localparam int WORD_W    = 32;
    localparam int STEP_W    = $clog2(WORD_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0]   ONE_SECOND_US = COUNT_W'(1000000);
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(20000);
    localparam logic [HALF_W-1:0]    HALF_RESET    = HALF_W'(100);
    localparam logic [STEP_W-1:0]    STEP_LAST     = STEP_W'(WORD_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_HALF_US = CFG_IDX_W'(1);

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_EDGE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture the input beat and clear the remainders
        logic div_step;    // one restoring-division bit on both lanes
        logic commit;      // apply the state update and load the result
        logic edge_taken;  // the pending edge passed the holdoff check
    } t_urjt_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_edge;     // captured beat is a falling edge
        logic edge_ok;     // holdoff check passes for the current state
    } t_urjt_status;

endpackage

`default_nettype wire

// ===== design/unlock_relay_jitter_timer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unlock_relay_jitter_timer
// Relays the network unlock pulse and schedules the next own pulse with a
// random jitter and force-quiet backoff.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per beat: tuser is the action (0 = one
//   microsecond tick, 1 = falling edge of the unlock input), tdata holds the
//   two raw random words. m_axis returns one result beat per item with the
//   unlock pulse, force-quiet and edge-accepted flags.
//   The config channel writes period_us (index 0) or backoff_half_us
//   (index 1); write only while no item is in flight.
// Timing:
//   The block works on one item at a time. A tick or an ignored edge passes
//   through the evaluate and commit states before the next ready; an accepted
//   edge also runs the bit-serial modulo that reduces both random words by
//   twice the half range before its commit.
//   The result sits in an output register; the next item is taken while it
//   waits. If the receiver stalls, the following item finishes its work and
//   holds in commit until the register frees up.
//   Synchronous reset restores the register defaults and timer state.
// ----------------------------------------------------------------------------
module unlock_relay_jitter_timer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Config write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [urjt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [urjt_pkg::PERIOD_W-1:0]       i_cfg_data,
    // Input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [2*urjt_pkg::WORD_W-1:0]       s_axis_tdata,  // random_jitter, random_backoff
    input  wire                                 s_axis_tuser,  // action
    // Result stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [7:0]                          m_axis_tdata   // unlock_pulse, force_quiet,
                                                               // edge_accepted, zero fill
);

    urjt_pkg::t_urjt_cmd    cmd;
    urjt_pkg::t_urjt_status status;

    assign o_cfg_ready = 1'b1;

    urjt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    urjt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (s_axis_tuser),
        .i_words     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== design/urjt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urjt_ctrl
// Sequencer: takes one input beat, runs the 32-step modulo for accepted
// edges, and commits the result into the output register when it is free.
// ----------------------------------------------------------------------------
module urjt_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    input  urjt_pkg::t_urjt_status i_status,
    output urjt_pkg::t_urjt_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic                           r_edge_taken;
    logic                           n_edge_taken;
    logic [urjt_pkg::STEP_W-1:0]    r_step;
    logic [urjt_pkg::STEP_W-1:0]    n_step;
    logic                           out_free;
    logic                           commit;

    assign out_free = !r_out_valid || m_axis_tready;
    assign commit   = (r_state == ST_COMMIT) && out_free;

    always_comb begin
        n_state      = r_state;
        n_edge_taken = r_edge_taken;
        n_step       = r_step;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_edge_taken = i_status.is_edge && i_status.edge_ok;
                if (i_status.is_edge && i_status.edge_ok) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_DIV: begin
                if (r_step == urjt_pkg::STEP_LAST) begin
                    n_step  = '0;
                    n_state = ST_COMMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (commit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_edge_taken <= 1'b0;
            r_step       <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_edge_taken <= n_edge_taken;
            r_step       <= n_step;
        end
    end

    assign s_axis_tready    = (r_state == ST_IDLE);
    assign m_axis_tvalid    = r_out_valid;
    assign o_cmd.load_in    = s_axis_tvalid && (r_state == ST_IDLE);
    assign o_cmd.div_step   = (r_state == ST_DIV);
    assign o_cmd.commit     = commit;
    assign o_cmd.edge_taken = r_edge_taken;

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!r_out_valid || m_axis_tready))
        else $error("result committed over an untaken beat");

    // Only one item is in flight: an accepted beat closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // The step counter only runs during the modulo.
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) |-> (r_step == '0))
        else $error("step counter running outside the modulo");

    // A new result appears only after a commit.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(commit))
        else $error("output valid rose without a commit");

    // Ticks and ignored edges never run the modulo.
    a_div_edge_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_edge_taken)
        else $error("modulo running for an item that is not an accepted edge");

endmodule

`default_nettype wire

// ===== design/urjt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urjt_datapath
// Configuration registers, timer state, two restoring-modulo lanes for the
// jitter and backoff words, and the result register.
// ----------------------------------------------------------------------------
module urjt_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    input  wire  [urjt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [urjt_pkg::PERIOD_W-1:0]       i_cfg_data,
    input  wire                                 i_action,
    input  wire  [2*urjt_pkg::WORD_W-1:0]       i_words,
    input  urjt_pkg::t_urjt_cmd                 i_cmd,
    output urjt_pkg::t_urjt_status              o_status,
    output logic [7:0]                          o_result
);

    localparam int PW = urjt_pkg::PERIOD_W;
    localparam int CW = urjt_pkg::COUNT_W;
    localparam int QW = urjt_pkg::QUIET_W;
    localparam int RW = urjt_pkg::RANGE_W;
    localparam int WW = urjt_pkg::WORD_W;

    // Configuration
    logic [PW-1:0]              r_period;
    logic [urjt_pkg::HALF_W-1:0] r_half;

    // Timer state
    logic [CW-1:0]  r_since;
    logic [CW-1:0]  n_since;
    logic [CW-1:0]  r_prior;
    logic [CW-1:0]  n_prior;
    logic [CW-1:0]  r_fire_cd;
    logic [CW-1:0]  n_fire_cd;
    logic           r_fire_armed;
    logic           n_fire_armed;
    logic [QW-1:0]  r_quiet;
    logic [QW-1:0]  n_quiet;

    // Item capture and modulo lanes
    logic           r_action;
    logic [WW-1:0]  r_word_j;
    logic [WW-1:0]  r_word_b;
    logic [RW-1:0]  r_rem_j;
    logic [RW-1:0]  r_rem_b;
    logic [RW:0]    shift_j;
    logic [RW:0]    shift_b;
    logic [RW:0]    range_ext;
    logic [RW-1:0]  range;

    logic [2:0]     r_result;
    logic           pulse;

    logic [RW-1:0]  jitter;
    logic [RW-1:0]  backoff;
    logic [CW-1:0]  delay;
    logic           stretch;

    assign range     = {r_half, 1'b0};
    assign range_ext = {1'b0, range};
    assign shift_j   = {r_rem_j, r_word_j[WW-1]};
    assign shift_b   = {r_rem_b, r_word_b[WW-1]};

    // An empty range yields zero for both draws.
    assign jitter  = (r_half == '0) ? '0 : r_rem_j;
    assign backoff = (r_half == '0) ? '0 : r_rem_b;

    assign o_status.is_edge = (r_action == urjt_pkg::ACTION_EDGE);
    assign o_status.edge_ok = (r_since >= urjt_pkg::ONE_SECOND_US) ||
                              ({r_since, 1'b0} >= {{(CW+1-PW){1'b0}}, r_period});

    // Stretch the period when the last interval was short or very long,
    // otherwise shrink it.
    assign stretch = (r_prior >= urjt_pkg::ONE_SECOND_US) ||
                     (r_prior <= CW'(r_period));

    always_comb begin
        if (stretch) begin
            delay = CW'(r_period) + CW'(jitter);
        end else if (CW'(r_period) > CW'(jitter)) begin
            delay = CW'(r_period) - CW'(jitter);
        end else begin
            delay = '0;
        end
    end

    always_comb begin
        n_since      = r_since;
        n_prior      = r_prior;
        n_fire_cd    = r_fire_cd;
        n_fire_armed = r_fire_armed;
        n_quiet      = r_quiet;
        pulse        = 1'b0;
        if (r_action == urjt_pkg::ACTION_TICK) begin
            if (r_since < urjt_pkg::ONE_SECOND_US) begin
                n_since = r_since + 1'b1;
            end
            if (r_quiet != '0) begin
                n_quiet = r_quiet - 1'b1;
            end
            if (r_fire_armed) begin
                if (r_fire_cd <= CW'(1)) begin
                    pulse        = 1'b1;
                    n_fire_armed = 1'b0;
                    n_fire_cd    = '0;
                end else begin
                    n_fire_cd = r_fire_cd - 1'b1;
                end
            end
        end else if (i_cmd.edge_taken) begin
            n_fire_cd    = (delay > CW'(backoff)) ? delay : CW'(backoff);
            n_fire_armed = 1'b1;
            n_quiet      = backoff;
            n_prior      = r_since;
            n_since      = '0;
            pulse        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= urjt_pkg::PERIOD_RESET;
            r_half       <= urjt_pkg::HALF_RESET;
            r_since      <= '0;
            r_prior      <= urjt_pkg::ONE_SECOND_US;
            r_fire_cd    <= CW'(urjt_pkg::PERIOD_RESET);
            r_fire_armed <= 1'b1;
            r_quiet      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    urjt_pkg::REG_PERIOD_US: begin
                        r_period <= i_cfg_data;
                    end
                    urjt_pkg::REG_BACKOFF_HALF_US: begin
                        r_half <= i_cfg_data[urjt_pkg::HALF_W-1:0];
                    end
                    default: begin
                        r_period <= r_period;
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_since      <= n_since;
                r_prior      <= n_prior;
                r_fire_cd    <= n_fire_cd;
                r_fire_armed <= n_fire_armed;
                r_quiet      <= n_quiet;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_word_j <= i_words[WW-1:0];
            r_word_b <= i_words[2*WW-1:WW];
            r_rem_j  <= '0;
            r_rem_b  <= '0;
        end else if (i_cmd.div_step) begin
            r_word_j <= {r_word_j[WW-2:0], 1'b0};
            r_word_b <= {r_word_b[WW-2:0], 1'b0};
            r_rem_j  <= (shift_j >= range_ext) ? RW'(shift_j - range_ext) : RW'(shift_j);
            r_rem_b  <= (shift_b >= range_ext) ? RW'(shift_b - range_ext) : RW'(shift_b);
        end
        if (i_cmd.commit) begin
            r_result <= {i_cmd.edge_taken && (r_action == urjt_pkg::ACTION_EDGE),
                         (n_quiet != '0), pulse};
        end
    end

    assign o_result = {5'b0, r_result};

endmodule

`default_nettype wire
